FILE: rtl/ppm_pkg.sv
`default_nettype none
package ppm_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_SAMPLE_WIDTH = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_KIND  = 2'd1;
   localparam logic [1:0] CSR_BIG_ENDIAN   = 2'd2;

   // sample width codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;

   // sample kind codes
   localparam logic [1:0] KIND_UNSIGNED = 2'd0;
   localparam logic [1:0] KIND_SIGNED   = 2'd1;
   localparam logic [1:0] KIND_FLOAT    = 2'd2;

   // reset values of the configuration
   localparam logic [1:0] RESET_WIDTH = WIDTH_16;
   localparam logic [1:0] RESET_KIND  = KIND_SIGNED;

   // full scale per format
   localparam logic [31:0] FS_U8  = 32'd255;
   localparam logic [31:0] FS_S8  = 32'd127;
   localparam logic [31:0] FS_U16 = 32'd65535;
   localparam logic [31:0] FS_S16 = 32'd32767;
   localparam logic [31:0] FS_U32 = 32'hffff_ffff;
   localparam logic [31:0] FS_S32 = 32'h7fff_ffff;

   // quotient is at most 2^16, so 17 restoring steps
   localparam int QUOT_BITS = 17;
   localparam int CNT_BITS  = $clog2(QUOT_BITS + 1);

   localparam logic [15:0] LEVEL_MAX = 16'hffff;

   typedef struct packed {
      logic [31:0] sample_bytes;
      logic        last_in_buffer;
   } req_type;

   typedef struct packed {
      logic [15:0] level;
      logic [31:0] peak_value;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_RUN,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic take_sample;
      logic div_start;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } sts_type;

endpackage
`default_nettype wire

FILE: rtl/ppm_ctrl.sv
`default_nettype none
module ppm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_last,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire ppm_pkg::sts_type  sts,
   output ppm_pkg::cmd_type       cmd
);

   ppm_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppm_pkg::ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ppm_pkg::ST_RUN: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_sample = 1'b1;
               if (req_last) begin
                  cmd.div_start = 1'b1;
                  state_in      = ppm_pkg::ST_DIV;
               end
            end
         end
         ppm_pkg::ST_DIV: begin
            if (!sts.div_done) begin
               cmd.div_step = 1'b1;
            end else if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ppm_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = ppm_pkg::ST_RUN;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: rtl/ppm_datapath.sv
`default_nettype none
module ppm_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [1:0]        csr_wdata,
   input  wire ppm_pkg::req_type  req_data,
   input  wire ppm_pkg::cmd_type  cmd,
   output ppm_pkg::sts_type       sts,
   output ppm_pkg::rsp_type       rsp_data
);

   logic [1:0]  width_ff, kind_ff;
   logic        big_endian_ff;
   logic [31:0] peak_ff, peak_in;
   logic [15:0] last_level_ff;
   logic [31:0] rem_ff, rem_in;
   logic [ppm_pkg::QUOT_BITS-1:0] quot_ff, quot_in;
   logic [31:0] fs_ff;
   logic [31:0] clamp_ff;
   logic        bad_ff;
   logic [ppm_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   ppm_pkg::rsp_type rsp_ff;

   logic [31:0] fs;
   logic [31:0] mag;
   logic [31:0] peak_new;
   logic [31:0] clamp;
   logic [32:0] trial;
   logic [15:0] level_calc;

   function automatic logic [31:0] float_mag(input logic [31:0] bits);
      logic [7:0]  ex;
      logic [23:0] man;
      logic [31:0] m32;
      logic [7:0]  rs;
      logic [31:0] res;
      ex  = bits[30:23];
      man = {1'b0, bits[22:0]};
      rs  = 8'd0;
      if (ex == 8'hff) begin
         res = (bits[22:0] != 23'd0) ? 32'd0 : 32'hffff_ffff;
      end else begin
         if (ex == 8'd0) begin
            ex = 8'd1;
         end else begin
            man[23] = 1'b1;
         end
         m32 = {8'd0, man};
         // 2^31 scale: value = man * 2^(ex - 119)
         if (ex > 8'd127) begin
            res = 32'hffff_ffff;
         end else if (ex >= 8'd119) begin
            res = m32 << (ex - 8'd119);
         end else begin
            rs  = 8'd119 - ex;
            res = (rs >= 8'd32) ? 32'd0 : (m32 >> rs);
         end
      end
      return res;
   endfunction

   // full scale of the current format, zero when unsupported
   always_comb begin
      fs = 32'd0;
      case (width_ff)
         ppm_pkg::WIDTH_8: begin
            if (kind_ff == ppm_pkg::KIND_UNSIGNED) fs = ppm_pkg::FS_U8;
            else if (kind_ff == ppm_pkg::KIND_SIGNED) fs = ppm_pkg::FS_S8;
         end
         ppm_pkg::WIDTH_16: begin
            if (kind_ff == ppm_pkg::KIND_UNSIGNED) fs = ppm_pkg::FS_U16;
            else if (kind_ff == ppm_pkg::KIND_SIGNED) fs = ppm_pkg::FS_S16;
         end
         ppm_pkg::WIDTH_32: begin
            if (kind_ff == ppm_pkg::KIND_UNSIGNED) fs = ppm_pkg::FS_U32;
            else if (kind_ff inside {ppm_pkg::KIND_SIGNED, ppm_pkg::KIND_FLOAT})
               fs = ppm_pkg::FS_S32;
         end
         default: fs = 32'd0;
      endcase
   end

   // sample magnitude
   always_comb begin
      logic [7:0]  b0, b1, b2, b3;
      logic [31:0] v;
      b0  = req_data.sample_bytes[7:0];
      b1  = req_data.sample_bytes[15:8];
      b2  = req_data.sample_bytes[23:16];
      b3  = req_data.sample_bytes[31:24];
      v   = 32'd0;
      mag = 32'd0;
      case (width_ff)
         ppm_pkg::WIDTH_8: begin
            v = {24'd0, b0};
            if (kind_ff == ppm_pkg::KIND_SIGNED && b0[7]) v = 32'h100 - v;
            mag = v;
         end
         ppm_pkg::WIDTH_16: begin
            v = big_endian_ff ? {16'd0, b0, b1} : {16'd0, b1, b0};
            if (kind_ff == ppm_pkg::KIND_SIGNED && v[15]) v = 32'h1_0000 - v;
            mag = v;
         end
         default: begin
            v = big_endian_ff ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
            if (kind_ff == ppm_pkg::KIND_FLOAT) mag = float_mag(v);
            else if (kind_ff == ppm_pkg::KIND_SIGNED && v[31]) mag = 32'd0 - v;
            else mag = v;
         end
      endcase
   end

   assign peak_new = (fs != 32'd0 && mag > peak_ff) ? mag : peak_ff;
   assign clamp    = (peak_new < fs) ? peak_new : fs;

   always_comb begin
      peak_in = peak_ff;
      if (cmd.take_sample) begin
         peak_in = cmd.div_start ? 32'd0 : peak_new;
      end
   end

   // restoring division of clamp * 2^16 by full scale
   assign trial = (cnt_ff == ppm_pkg::CNT_BITS'(ppm_pkg::QUOT_BITS)) ?
                  {1'b0, rem_ff} : {rem_ff, 1'b0};

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      if (cmd.div_start) begin
         rem_in  = clamp;
         quot_in = '0;
         cnt_in  = ppm_pkg::CNT_BITS'(ppm_pkg::QUOT_BITS);
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff - ppm_pkg::CNT_BITS'(1);
         if (trial >= {1'b0, fs_ff}) begin
            rem_in  = 32'(trial - {1'b0, fs_ff});
            quot_in = {quot_ff[ppm_pkg::QUOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = trial[31:0];
            quot_in = {quot_ff[ppm_pkg::QUOT_BITS-2:0], 1'b0};
         end
      end
   end

   assign level_calc = quot_ff[ppm_pkg::QUOT_BITS-1] ? ppm_pkg::LEVEL_MAX : quot_ff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= ppm_pkg::RESET_WIDTH;
         kind_ff       <= ppm_pkg::RESET_KIND;
         big_endian_ff <= 1'b0;
         peak_ff       <= 32'd0;
         last_level_ff <= 16'd0;
         cnt_ff        <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ppm_pkg::CSR_SAMPLE_WIDTH: width_ff      <= csr_wdata;
               ppm_pkg::CSR_SAMPLE_KIND:  kind_ff       <= csr_wdata;
               ppm_pkg::CSR_BIG_ENDIAN:   big_endian_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         peak_ff <= peak_in;
         cnt_ff  <= cnt_in;
         if (cmd.load_rsp && !bad_ff) last_level_ff <= level_calc;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (cmd.div_start) begin
         fs_ff    <= fs;
         clamp_ff <= clamp;
         bad_ff   <= (fs == 32'd0);
      end
      if (cmd.load_rsp) begin
         rsp_ff.level      <= bad_ff ? last_level_ff : level_calc;
         rsp_ff.peak_value <= bad_ff ? 32'd0 : clamp_ff;
      end
   end

   assign sts.div_done = (cnt_ff == '0);
   assign rsp_data     = rsp_ff;

endmodule
`default_nettype wire

FILE: rtl/pcm_peak_level_meter.sv
`default_nettype none
// pcm peak level meter: takes one raw sample item per cycle (8/16/32-bit,
// unsigned, signed or float, either byte order, set through the csr port
// while idle) and tracks the peak magnitude. an item flagged last_in_buffer
// closes the buffer: the peak is clamped to full scale and divided by a
// restoring divider, one quotient bit per cycle, before the result is handed
// to the output register; the hand-off waits while the previous result still
// sits unaccepted there; req_ready is low during that time. the output
// register lets the next buffer start while a result waits. an unsupported
// format repeats the previous level with a zero peak. no clearing pass after
// reset.
module pcm_peak_level_meter (
   input  wire logic              clock,
   input  wire logic              reset,
   // sample item channel
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ppm_pkg::req_type  req_data,
   // level result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ppm_pkg::rsp_type       rsp_data,
   // configuration writes
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [1:0]        csr_wdata
);

   ppm_pkg::cmd_type cmd;
   ppm_pkg::sts_type sts;

   // config writes never stall
   assign csr_ready = 1'b1;

   // sequencer: sample intake, divide, result hand-off
   ppm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_data.last_in_buffer),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // decode, peak tracking, divider and result register
   ppm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
